// ===== src/srlas_pkg.sv =====
// ----------------------------------------------------------------------------
// srlas_pkg: shared types and constants
// Constants, queue entry control struct and back-end state type for the
// self-repeat local alignment score block.
// ----------------------------------------------------------------------------
`default_nettype none

package srlas_pkg;

   // default maximum stored sequence length
   localparam int MaxLenDefault = 1024;
   // residue code width
   localparam int ResidueW      = 8;
   // result score width and its saturation value
   localparam int ScoreW        = 11;
   localparam int ScoreSat      = 2047;
   // depth of the queue between front and back
   localparam int QueueDepth    = 4;

   // control bits of one classified item
   typedef struct packed {
      logic store;     // residue goes into the store
      logic last;      // sequence ends with this item
      logic too_long;  // residues were dropped in this sequence
   } ctl_type;

   // back-end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PRE1,
      BK_PRE2,
      BK_CELL,
      BK_DONE
   } back_state_type;

endpackage

`default_nettype wire

// ===== src/self_repeat_local_alignment_score_top.sv =====
// ----------------------------------------------------------------------------
// self_repeat_local_alignment_score_top: local self-alignment scorer
// Residues are pushed one per cycle while req_full is low; after the last
// one, the best local self-alignment score of the upper triangle comes out.
//
// Input channel: req_push/req_full. Residues are stored up to MAX_LEN; more
// are dropped and flagged in rsp_too_long. req_last_residue ends a sequence.
// Result channel: rsp_empty/rsp_pop, one result per sequence, held in an
// output register until popped.
// Throughput: one residue per cycle while loading and req_full is low. After
// the last residue the back end sweeps one cell per cycle from a row buffer
// with one read and one write port, after setup states BK_PRE1 and BK_PRE2
// for each row. A 4-entry queue parts the front from the back, so up to
// four residues of the next sequence are taken during a sweep.
// Reset: synchronous; queue, counters and result register clear. No memory
// clearing pass is needed. A stalled receiver holds the back end in its
// done state; the queue then fills and req_full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module self_repeat_local_alignment_score_top #(
   parameter int MAX_LEN = srlas_pkg::MaxLenDefault
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   input  wire logic [srlas_pkg::ResidueW-1:0] req_residue,
   input  wire logic                           req_last_residue,
   output logic                                req_full,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [srlas_pkg::ScoreW-1:0]        rsp_best_score,
   output logic                                rsp_too_long
);

   localparam int EW = $bits(srlas_pkg::ctl_type) + srlas_pkg::ResidueW
                       + $clog2(MAX_LEN + 1);

   logic          fq_push;
   logic [EW-1:0] fq_data;
   logic          fq_full;
   logic          qb_pop;
   logic [EW-1:0] qb_data;
   logic          qb_empty;

   srlas_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_residue      (req_residue),
      .req_last_residue (req_last_residue),
      .req_full         (req_full),
      .q_push           (fq_push),
      .q_data           (fq_data),
      .q_full           (fq_full)
   );

   srlas_queue #(.WIDTH(EW), .DEPTH(srlas_pkg::QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_data),
      .full      (fq_full),
      .pop       (qb_pop),
      .pop_data  (qb_data),
      .empty     (qb_empty)
   );

   srlas_back #(.MAX_LEN(MAX_LEN)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (qb_empty),
      .q_data         (qb_data),
      .q_pop          (qb_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_best_score (rsp_best_score),
      .rsp_too_long   (rsp_too_long)
   );

endmodule

`default_nettype wire

// ===== src/srlas_queue.sv =====
// ----------------------------------------------------------------------------
// srlas_queue: small register queue
// Holds classified items between the front and the back so each side can
// stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module srlas_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [NW-1:0]    fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (fill_ff == NW'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rptr_ff];

   // pointer and fill count update
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/srlas_front.sv =====
// ----------------------------------------------------------------------------
// srlas_front: input classifier
// Accepts residues, assigns each a store index or marks it dropped, and
// tracks sequence length and overflow until the last residue.
// ----------------------------------------------------------------------------
`default_nettype none

module srlas_front #(
   parameter int MAX_LEN = srlas_pkg::MaxLenDefault
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input channel
   input  wire logic                            req_push,
   input  wire logic [srlas_pkg::ResidueW-1:0]  req_residue,
   input  wire logic                            req_last_residue,
   output logic                                 req_full,
   // toward the queue
   output logic                                 q_push,
   output logic [$bits(srlas_pkg::ctl_type)+srlas_pkg::ResidueW+$clog2(MAX_LEN+1)-1:0]
                                                q_data,
   input  wire logic                            q_full
);

   localparam int CW = $clog2(MAX_LEN + 1);

   logic [CW-1:0]      count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic               accept;
   srlas_pkg::ctl_type ctl;

   assign req_full = q_full;
   assign accept   = req_push & ~q_full;
   assign q_push   = accept;

   // classify: store while room remains, otherwise drop and flag
   always_comb begin
      ctl.store    = (count_ff < CW'(MAX_LEN));
      ctl.last     = req_last_residue;
      ctl.too_long = ovf_ff | ~ctl.store;
   end

   assign q_data = {ctl, req_residue, count_ff};

   // length and overflow tracking
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_last_residue) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else if (ctl.store) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/srlas_back.sv =====
// ----------------------------------------------------------------------------
// srlas_back: store and triangle sweep engine
// Writes residues and row-0 scores as items arrive, then sweeps the upper
// triangle one cell per cycle over a single row buffer and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module srlas_back #(
   parameter int MAX_LEN = srlas_pkg::MaxLenDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // from the queue
   input  wire logic                          q_empty,
   input  wire logic [$bits(srlas_pkg::ctl_type)+srlas_pkg::ResidueW+$clog2(MAX_LEN+1)-1:0]
                                              q_data,
   output logic                               q_pop,
   // result channel
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [srlas_pkg::ScoreW-1:0]       rsp_best_score,
   output logic                               rsp_too_long
);

   localparam int CW    = $clog2(MAX_LEN + 1);
   localparam int AW    = $clog2(MAX_LEN);
   localparam int Depth = 1 << AW;
   localparam int RW    = srlas_pkg::ResidueW;
   localparam int CtlW  = $bits(srlas_pkg::ctl_type);
   localparam int EW    = CtlW + RW + CW;

   srlas_pkg::back_state_type state_ff, state_in;

   // queue entry fields
   srlas_pkg::ctl_type q_ctl;
   logic [RW-1:0]      q_res;
   logic [CW-1:0]      q_idx;
   logic [CW-1:0]      q_len;

   // storage
   logic [RW-1:0] res_mem_ff [Depth];
   logic [CW-1:0] row_mem_ff [Depth];
   logic [RW-1:0] res_rd_ff;
   logic [CW-1:0] row_rd_ff;

   logic          res_we;
   logic [AW-1:0] res_waddr;
   logic [AW-1:0] res_raddr;
   logic          row_we;
   logic [AW-1:0] row_waddr;
   logic [CW-1:0] row_wdata;
   logic [AW-1:0] row_raddr;

   // sweep registers
   logic [RW-1:0] res0_ff;
   logic [RW-1:0] resi_ff;
   logic [CW-1:0] len_ff;
   logic [CW-1:0] i_ff;
   logic [CW-1:0] j_ff;
   logic [CW-1:0] diag_ff;
   logic [CW-1:0] left_ff;
   logic [CW-1:0] best_ff;
   logic          tl_ff;

   // result register
   logic                      rsp_valid_ff;
   logic [srlas_pkg::ScoreW-1:0] rsp_score_ff;
   logic                      rsp_tl_ff;

   // cell datapath
   logic [CW-1:0] col_next;
   logic [CW-1:0] j_p2;
   logic [CW-1:0] up_dec;
   logic [CW-1:0] left_dec;
   logic [CW-1:0] diag_val;
   logic [CW-1:0] cell_max;
   logic [CW-1:0] cell_v;
   logic          last_cell;
   logic          last_row;
   logic          row0_match;
   logic [31:0]   best_ext;

   function automatic logic [CW-1:0] dec_floor(input logic [CW-1:0] v);
      return (v != '0) ? v - CW'(1) : '0;
   endfunction

   assign q_ctl = q_data[EW-1 -: CtlW];
   assign q_res = q_data[CW +: RW];
   assign q_idx = q_data[CW-1:0];
   assign q_len = q_ctl.store ? q_idx + CW'(1) : q_idx;

   assign row0_match = (q_res == res0_ff);

   // one cell: max of up-gap, left-gap, diagonal with match score, floor 0
   always_comb begin
      col_next  = i_ff + j_ff + CW'(1);
      j_p2      = j_ff + CW'(2);
      up_dec    = dec_floor(row_rd_ff);
      left_dec  = dec_floor(left_ff);
      diag_val  = (res_rd_ff == resi_ff) ? diag_ff + CW'(1) : dec_floor(diag_ff);
      cell_max  = (up_dec > left_dec) ? up_dec : left_dec;
      cell_v    = (diag_val > cell_max) ? diag_val : cell_max;
      last_cell = (col_next == len_ff);
      last_row  = (i_ff + CW'(2) == len_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srlas_pkg::BK_IDLE: begin
            if (!q_empty && q_ctl.last) begin
               state_in = (q_len > CW'(2)) ? srlas_pkg::BK_PRE1 : srlas_pkg::BK_DONE;
            end
         end
         srlas_pkg::BK_PRE1: state_in = srlas_pkg::BK_PRE2;
         srlas_pkg::BK_PRE2: state_in = srlas_pkg::BK_CELL;
         srlas_pkg::BK_CELL: begin
            if (last_cell) begin
               state_in = last_row ? srlas_pkg::BK_DONE : srlas_pkg::BK_PRE1;
            end
         end
         srlas_pkg::BK_DONE: begin
            if (!rsp_valid_ff) begin
               state_in = srlas_pkg::BK_IDLE;
            end
         end
         default: state_in = srlas_pkg::BK_IDLE;
      endcase
   end

   // memory port control
   always_comb begin
      q_pop     = 1'b0;
      res_we    = 1'b0;
      res_waddr = q_idx[AW-1:0];
      res_raddr = i_ff[AW-1:0];
      row_we    = 1'b0;
      row_waddr = q_idx[AW-1:0];
      row_wdata = CW'(row0_match);
      row_raddr = j_p2[AW-1:0];
      unique case (state_ff)
         srlas_pkg::BK_IDLE: begin
            q_pop  = ~q_empty;
            res_we = ~q_empty & q_ctl.store;
            row_we = ~q_empty & q_ctl.store & (q_idx != '0);
         end
         srlas_pkg::BK_PRE1: begin
            row_raddr = AW'(1);
            res_raddr = i_ff[AW-1:0];
         end
         srlas_pkg::BK_PRE2: begin
            row_raddr = AW'(2);
            res_raddr = col_next[AW-1:0];
         end
         srlas_pkg::BK_CELL: begin
            row_we    = 1'b1;
            row_waddr = j_ff[AW-1:0];
            row_wdata = cell_v;
            row_raddr = j_p2[AW-1:0];
            res_raddr = col_next[AW-1:0];
         end
         srlas_pkg::BK_DONE: begin
            q_pop = 1'b0;
         end
         default: q_pop = 1'b0;
      endcase
   end

   // residue store and row buffer
   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem_ff[res_waddr] <= q_res;
      end
      res_rd_ff <= res_mem_ff[res_raddr];
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem_ff[row_waddr] <= row_wdata;
      end
      row_rd_ff <= row_mem_ff[row_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srlas_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sweep registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         srlas_pkg::BK_IDLE: begin
            if (!q_empty) begin
               if (q_ctl.store && q_idx == '0) begin
                  res0_ff <= q_res;
                  best_ff <= '0;
               end else if (q_ctl.store && row0_match) begin
                  best_ff <= CW'(1);
               end
               if (q_ctl.last) begin
                  len_ff <= q_len;
                  tl_ff  <= q_ctl.too_long;
                  i_ff   <= CW'(1);
               end
            end
         end
         srlas_pkg::BK_PRE1: begin
            // column restarts so the setup read fetches residue i+1
            j_ff <= '0;
         end
         srlas_pkg::BK_PRE2: begin
            diag_ff <= row_rd_ff;
            resi_ff <= res_rd_ff;
            left_ff <= '0;
            j_ff    <= CW'(1);
         end
         srlas_pkg::BK_CELL: begin
            diag_ff <= row_rd_ff;
            left_ff <= cell_v;
            if (cell_v > best_ff) begin
               best_ff <= cell_v;
            end
            if (last_cell) begin
               i_ff <= i_ff + CW'(1);
            end else begin
               j_ff <= j_ff + CW'(1);
            end
         end
         srlas_pkg::BK_DONE: begin
            tl_ff <= tl_ff;
         end
         default: tl_ff <= tl_ff;
      endcase
   end

   // result register with saturation
   assign best_ext = 32'(best_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == srlas_pkg::BK_DONE && !rsp_valid_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == srlas_pkg::BK_DONE && !rsp_valid_ff) begin
         rsp_score_ff <= (best_ext > 32'(srlas_pkg::ScoreSat))
                         ? srlas_pkg::ScoreW'(srlas_pkg::ScoreSat)
                         : best_ext[srlas_pkg::ScoreW-1:0];
         rsp_tl_ff    <= tl_ff;
      end
   end

   assign rsp_empty      = ~rsp_valid_ff;
   assign rsp_best_score = rsp_score_ff;
   assign rsp_too_long   = rsp_tl_ff;

endmodule

`default_nettype wire

// ===== src/srlas_checker.sv =====
// ----------------------------------------------------------------------------
// srlas_checker: port-level checks
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module srlas_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_full,
   input wire logic                           rsp_empty,
   input wire logic                           rsp_pop,
   input wire logic [srlas_pkg::ScoreW-1:0]   rsp_best_score,
   input wire logic                           rsp_too_long
);

   // reset leaves the queue open and no result waiting
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("state not clean after reset");

   // a waiting result holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_best_score) && $stable(rsp_too_long)))
      else $error("result changed while waiting");

   // the result register does not refill in the cycle of its pop
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop) |=> rsp_empty)
      else $error("result reloaded in the cycle of its pop");

endmodule

bind self_repeat_local_alignment_score_top srlas_checker u_srlas_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_best_score (rsp_best_score),
   .rsp_too_long   (rsp_too_long)
);

`default_nettype wire

// ===== dv/self_repeat_local_alignment_score_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// self_repeat_local_alignment_score_top_test: self-alignment scorer testbench
// Pushes residue sequences into the block and scores each one with a local
// copy of the triangle sweep. Every popped result is matched field by field
// against the oldest pending score. A short stimulus table comes first; it
// covers single residues, runs of equal residues, row-zero matches and an
// overlong sequence. Random sequences with random idling on both sides follow.
// ----------------------------------------------------------------------------

module self_repeat_local_alignment_score_top_test;

   localparam int MaxLen       = srlas_pkg::MaxLenDefault;
   localparam int RandomItems  = 250;
   localparam int DrainCycles  = 32;
   localparam int CycleLimit   = 4_000_000;
   localparam int ShownErrors  = 10;

   // one popped result
   typedef struct packed {
      logic [srlas_pkg::ScoreW-1:0] best;
      logic                         too_long;
   } score_rec_type;

   // one stimulus table row: a run of equal residues, last on its final item
   typedef struct packed {
      logic [srlas_pkg::ResidueW-1:0] residue;
      logic [10:0]                    run_len;
      logic                           last;
      logic                           typed;
      logic [srlas_pkg::ScoreW-1:0]   best;
      logic                           too_long;
   } dir_row_type;

   localparam int DirRows = 19;
   localparam dir_row_type DirTable [DirRows] = '{
      // single residue: nothing off the diagonal
      '{8'h41, 11'd1,    1'b1, 1'b1, 11'd0,    1'b0},
      // two equal residues, both zero
      '{8'h00, 11'd1,    1'b0, 1'b0, 11'd0,    1'b0},
      '{8'h00, 11'd1,    1'b1, 1'b1, 11'd1,    1'b0},
      // two different residues, extremes of the byte
      '{8'hFF, 11'd1,    1'b0, 1'b0, 11'd0,    1'b0},
      '{8'h00, 11'd1,    1'b1, 1'b1, 11'd0,    1'b0},
      // run of eight equal residues scores length minus one
      '{8'hFF, 11'd8,    1'b1, 1'b1, 11'd7,    1'b0},
      // alternating pair, matches against the first residue in row zero
      '{8'h41, 11'd1,    1'b0, 1'b0, 11'd0,    1'b0},
      '{8'h43, 11'd1,    1'b0, 1'b0, 11'd0,    1'b0},
      '{8'h41, 11'd1,    1'b0, 1'b0, 11'd0,    1'b0},
      '{8'h43, 11'd1,    1'b0, 1'b0, 11'd0,    1'b0},
      '{8'h41, 11'd1,    1'b1, 1'b0, 11'd0,    1'b0},
      // checkerboard bytes
      '{8'h55, 11'd1,    1'b0, 1'b0, 11'd0,    1'b0},
      '{8'hAA, 11'd1,    1'b0, 1'b0, 11'd0,    1'b0},
      '{8'h55, 11'd1,    1'b0, 1'b0, 11'd0,    1'b0},
      '{8'hAA, 11'd1,    1'b1, 1'b0, 11'd0,    1'b0},
      // nibble swap, with the mismatch at the end
      '{8'h0F, 11'd2,    1'b0, 1'b0, 11'd0,    1'b0},
      '{8'hF0, 11'd1,    1'b1, 1'b0, 11'd0,    1'b0},
      // overlong run: last residue dropped, full-length score, flag set
      '{8'h41, 11'd1025, 1'b1, 1'b1, 11'd1023, 1'b1},
      // flag must clear for the next sequence
      '{8'h7E, 11'd1,    1'b1, 1'b1, 11'd0,    1'b0}
   };

   logic                           clock            = 1'b0;
   logic                           reset            = 1'b1;
   logic                           req_push         = 1'b0;
   logic [srlas_pkg::ResidueW-1:0] req_residue      = '0;
   logic                           req_last_residue = 1'b0;
   logic                           req_full;
   logic                           rsp_empty;
   logic                           rsp_pop          = 1'b0;
   logic [srlas_pkg::ScoreW-1:0]   rsp_best_score;
   logic                           rsp_too_long;

   // scoring model state
   logic [srlas_pkg::ResidueW-1:0] seq_store [MaxLen];
   int                             tri_row   [MaxLen];
   int                             seq_len      = 0;
   bit                             seq_dropped  = 1'b0;

   score_rec_type pending_scores [$];
   int            mismatch_count = 0;
   int            items_sent     = 0;
   int            cycle_count    = 0;
   int            pop_hold       = 0;
   bit            calm           = 1'b0;

   self_repeat_local_alignment_score_top #(
      .MAX_LEN (MaxLen)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_residue      (req_residue),
      .req_last_residue (req_last_residue),
      .req_full         (req_full),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_best_score   (rsp_best_score),
      .rsp_too_long     (rsp_too_long)
   );

   always #5 clock = ~clock;

   // best cell of the upper triangle over the stored residues
   function logic [srlas_pkg::ScoreW-1:0] sweep_best(input int n);
      int best, i, j, v;
      best = 0;
      if (n == 0) return '0;
      tri_row[0] = 0;
      for (j = 1; j < n; j++) begin
         tri_row[j] = (seq_store[0] == seq_store[j]) ? 1 : 0;
         if (tri_row[j] > best) best = tri_row[j];
      end
      for (i = 1; i < n; i++) begin
         tri_row[0] = 0;
         for (j = 1; j + i < n; j++) begin
            v = (tri_row[j + 1] > tri_row[j - 1]) ? tri_row[j + 1] - 1 : tri_row[j - 1] - 1;
            if (tri_row[j] + ((seq_store[i] == seq_store[i + j]) ? 1 : -1) > v)
               v = tri_row[j] + ((seq_store[i] == seq_store[i + j]) ? 1 : -1);
            if (v < 0) v = 0;
            tri_row[j] = v;
            if (v > best) best = v;
         end
      end
      if (best > srlas_pkg::ScoreSat) best = srlas_pkg::ScoreSat;
      return best[srlas_pkg::ScoreW-1:0];
   endfunction

   // store one residue; on the last one, score the sequence and start over
   task score_residue(input logic [srlas_pkg::ResidueW-1:0] res, input logic last,
                      output bit fired, output score_rec_type rec);
      fired = 1'b0;
      rec   = '0;
      if (seq_len < MaxLen) begin
         seq_store[seq_len] = res;
         seq_len++;
      end else begin
         seq_dropped = 1'b1;
      end
      if (last) begin
         rec.best     = sweep_best(seq_len);
         rec.too_long = seq_dropped;
         fired        = 1'b1;
         seq_len      = 0;
         seq_dropped  = 1'b0;
      end
   endtask

   // idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // push one residue, wait for it to be taken, queue its score if any
   task send_residue(input logic [srlas_pkg::ResidueW-1:0] res, input logic last,
                     input logic typed, input score_rec_type typed_rec);
      int            gap;
      bit            fired;
      score_rec_type rec;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_residue      <= res;
      req_last_residue <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      score_residue(res, last, fired, rec);
      if (fired) pending_scores.push_back(typed ? typed_rec : rec);
      items_sent++;
   endtask

   // one random sequence: plain bytes, a small alphabet, or a mutated motif
   task send_random_sequence();
      int                             len, mode, k, motif_len;
      logic [srlas_pkg::ResidueW-1:0] alphabet [4];
      logic [srlas_pkg::ResidueW-1:0] res;
      k = $urandom_range(0, 99);
      if (k < 70)      len = $urandom_range(1, 12);
      else if (k < 95) len = $urandom_range(13, 40);
      else             len = $urandom_range(41, 64);
      mode      = $urandom_range(0, 2);
      motif_len = $urandom_range(2, 4);
      for (k = 0; k < 4; k++) alphabet[k] = srlas_pkg::ResidueW'($urandom_range(0, 255));
      for (k = 0; k < len; k++) begin
         case (mode)
            0: res = srlas_pkg::ResidueW'($urandom_range(0, 255));
            1: res = alphabet[$urandom_range(0, 3)];
            default: begin
               res = alphabet[k % motif_len];
               if ($urandom_range(0, 9) == 0)
                  res = srlas_pkg::ResidueW'($urandom_range(0, 255));
            end
         endcase
         send_residue(res, k == len - 1, 1'b0, '0);
      end
   endtask

   // count and show mismatches
   task note_mismatch(input string what, input score_rec_type want);
      if (mismatch_count < ShownErrors)
         $display("MISMATCH %s: expected best=%0d too_long=%0d, got best=%0d too_long=%0d",
                  what, want.best, want.too_long, rsp_best_score, rsp_too_long);
      mismatch_count++;
   endtask

   // result checker
   always @(posedge clock) begin : check_results
      score_rec_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_scores.size() == 0) begin
            note_mismatch("unexpected result", '0);
         end else begin
            want = pending_scores.pop_front();
            if (rsp_best_score !== want.best || rsp_too_long !== want.too_long)
               note_mismatch("result", want);
         end
      end
   end

   // result side stalls
   always @(posedge clock) begin : drive_pop
      int h;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (rsp_pop && !rsp_empty) begin
         h = pick_gap();
         if (h > 0) begin
            rsp_pop  <= 1'b0;
            pop_hold <= h - 1;
         end
      end else if (pop_hold > 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      int            row_idx, k, random_start;
      score_rec_type typed_rec;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // stimulus table
      for (row_idx = 0; row_idx < DirRows; row_idx++) begin
         typed_rec.best     = DirTable[row_idx].best;
         typed_rec.too_long = DirTable[row_idx].too_long;
         for (k = 0; k < DirTable[row_idx].run_len; k++)
            send_residue(DirTable[row_idx].residue,
                         DirTable[row_idx].last && (k == DirTable[row_idx].run_len - 1),
                         DirTable[row_idx].typed, typed_rec);
      end

      // random sequences, with calm stretches now and then
      random_start = items_sent;
      while (items_sent - random_start < RandomItems) begin
         calm = ($urandom_range(0, 4) == 0);
         send_random_sequence();
      end
      calm = 1'b0;
      req_push <= 1'b0;

      // drain
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== self_repeat_local_alignment_score_top.f =====
src/srlas_pkg.sv
src/srlas_queue.sv
src/srlas_front.sv
src/srlas_back.sv
src/self_repeat_local_alignment_score_top.sv
src/srlas_checker.sv
dv/self_repeat_local_alignment_score_top_test.sv
